[rtl/clook_pkg.sv]
// ----------------------------------------------------------------------------
// clook_pkg
// Shared constants and payload types of the c-look request scheduler.
// ----------------------------------------------------------------------------
package clook_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SECTOR_W    = 32;
  localparam int TAG_W       = 8;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [1:0] ST_ADDED      = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic                command;
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SECTOR_W-1:0] out_sector;
    logic [TAG_W-1:0]    out_tag;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the word and the per-cell compares
    logic update;  // apply insert or dispatch, load the result register
  } dp_cmd_t;

endpackage

[rtl/clook_datapath.sv]
// ----------------------------------------------------------------------------
// clook_datapath
// Row of compare-and-shift cells holding the sorted queue, head position
// and the result register.
// ----------------------------------------------------------------------------
module clook_datapath import clook_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  logic [SECTOR_W-1:0]    sec_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]       tag_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]       count_r;
  logic [SECTOR_W-1:0]    head_r;
  logic                   known_r;
  in_item_t               item_r;
  logic [QUEUE_DEPTH-1:0] gb_r;
  logic [QUEUE_DEPTH-1:0] gb_nxt;
  logic [QUEUE_DEPTH-1:0] at_or_after;
  out_item_t              out_r;
  logic                   s_behind;
  logic                   is_full;
  logic                   is_empty;
  logic                   do_add;
  logic                   do_disp;

  localparam logic [QUEUE_DEPTH-1:0] ONES = {QUEUE_DEPTH{1'b1}};

  // per-cell sweep order compare against the incoming sector
  always_comb begin
    s_behind = known_r && (in_data.sector < head_r);
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      logic e_behind;
      e_behind = known_r && (sec_r[k] < head_r);
      if (CNT_W'(k) >= count_r) begin
        gb_nxt[k] = 1'b0;
      end else if (s_behind != e_behind) begin
        gb_nxt[k] = e_behind;
      end else begin
        gb_nxt[k] = in_data.sector < sec_r[k];
      end
    end
  end

  // cell k is at or past the insertion point
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      at_or_after[k] = (|(gb_r & ~(ONES << (k + 1)))) || (CNT_W'(k) >= count_r);
    end
  end

  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign do_add   = cmd.update && (item_r.command == CMD_ADD) && !is_full;
  assign do_disp  = cmd.update && (item_r.command == CMD_DISPATCH) && !is_empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      gb_r   <= gb_nxt;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic prev_after;
    if (g == 0) begin : g_first
      assign prev_after = 1'b0;
    end else begin : g_rest
      assign prev_after = at_or_after[g-1];
    end

    always_ff @(posedge clk) begin
      if (do_add) begin
        if (prev_after) begin
          if (g > 0) begin
            sec_r[g] <= sec_r[(g > 0) ? g - 1 : 0];
            tag_r[g] <= tag_r[(g > 0) ? g - 1 : 0];
          end
        end else if (at_or_after[g]) begin
          sec_r[g] <= item_r.sector;
          tag_r[g] <= item_r.tag;
        end
      end else if (do_disp) begin
        if (g < QUEUE_DEPTH - 1) begin
          sec_r[g] <= sec_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
          tag_r[g] <= tag_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      known_r <= 1'b0;
    end else if (do_add) begin
      count_r <= count_r + CNT_W'(1);
    end else if (do_disp) begin
      count_r <= count_r - CNT_W'(1);
      head_r  <= sec_r[0];
      known_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r.out_sector <= '0;
      out_r.out_tag    <= '0;
      if (item_r.command == CMD_ADD) begin
        out_r.status <= is_full ? ST_FULL : ST_ADDED;
      end else if (is_empty) begin
        out_r.status <= ST_EMPTY;
      end else begin
        out_r.status     <= ST_DISPATCHED;
        out_r.out_sector <= sec_r[0];
        out_r.out_tag    <= tag_r[0];
      end
    end
  end

  assign out_data = out_r;

endmodule

[rtl/clook_ctrl.sv]
// ----------------------------------------------------------------------------
// clook_ctrl
// Handshake controller: takes a word, sequences the update, owns out_valid.
// ----------------------------------------------------------------------------
module clook_ctrl import clook_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic can_upd;

  assign in_stall = (state_r != ST_IDLE);
  // result slot is free or being emptied this cycle
  assign can_upd  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = 1'b0;
    cmd.update    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (can_upd) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/c_look_request_scheduler.sv]
// ----------------------------------------------------------------------------
// c_look_request_scheduler
// Each accepted word takes a compare step, then a shift step that loads
// the result word; the shift step waits while a held result is stalled.
// A waiting result does not block taking the next input word.
// Reset (rst_n low, synchronous): queue empty, head position 0, no dispatch
// seen yet, no result pending; queue storage itself is not cleared.
// ----------------------------------------------------------------------------
module c_look_request_scheduler import clook_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;

  clook_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  clook_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
